/* rtl/acb_pkg.sv */
// Shared types, operation codes and constants for the animation channel bank.
`default_nettype none
package acb_pkg;

    localparam int CHANNELS_DEF   = 16;
    localparam int MAX_FRAMES_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int PERIOD_W       = 31;

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_LOAD    = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_RESTART = 3'd3;
    localparam logic [2:0] MODE_ALIGN   = 3'd4;
    localparam logic [2:0] MODE_RSTALL  = 3'd5;

    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_LOAD    = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;
    localparam logic [2:0] OP_ALIGN   = 3'd5;
    localparam logic [2:0] OP_RSTALL  = 3'd6;

    localparam int FL_STOP = 0;
    localparam int FL_ONE  = 1;
    localparam int FL_CRIT = 2;
    localparam int FL_TGT  = 3;
    localparam int FL_LINK = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  channel;
        logic [31:0] time_value;
        logic [30:0] frame_period;
        logic [6:0]  frame_total;
        logic        one_shot;
        logic        critical_only;
        logic        has_target;
        logic        link_enable;
        logic [3:0]  link_channel;
    } in_item_t;

    typedef struct packed {
        logic [3:0] out_channel;
        logic [5:0] frame_index;
        logic       one_shot_done;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [2:0] op;
        in_item_t   item;
    } cmd_t;

endpackage
`default_nettype wire

/* rtl/acb_front.sv */
// Input stage: decodes each item into an operation and queues it for the back end.
`default_nettype none
module acb_front #(
    parameter int CHANNELS = acb_pkg::CHANNELS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire acb_pkg::in_item_t in_item,
    output logic                  cmd_valid,
    input  wire logic             cmd_ready,
    output acb_pkg::cmd_t         cmd
);
    import acb_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       dec;
    logic       in_range;
    logic       push, pop;

    always_comb
    begin
        in_range = 32'(in_item.channel) < CHANNELS;
        dec.item = in_item;
        case (in_item.mode)
            MODE_TICK:    dec.op = OP_TICK;
            MODE_LOAD:    dec.op = in_range ? OP_LOAD : OP_NONE;
            MODE_STOP:    dec.op = in_range ? OP_STOP : OP_NONE;
            MODE_RESTART: dec.op = in_range ? OP_RESTART : OP_NONE;
            MODE_ALIGN:   dec.op = OP_ALIGN;
            MODE_RSTALL:  dec.op = OP_RSTALL;
            default:      dec.op = OP_NONE;
        endcase
    end

    assign in_ready  = count_reg != 2'd2;
    assign cmd_valid = count_reg != 2'd0;
    assign cmd       = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/acb_div.sv */
// Serial restoring divider: 32-bit dividend by 31-bit divisor, one bit a cycle.
`default_nettype none
module acb_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [30:0]      remainder
);
    logic [30:0] acc_reg, acc_next;
    logic [31:0] quo_reg, quo_next;
    logic [30:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] sh;
    logic        ge;

    assign sh        = {acc_reg, quo_reg[31]};
    assign ge        = sh >= {1'b0, dvs_reg};
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = acc_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = ge ? 31'(sh - {1'b0, dvs_reg}) : sh[30:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/acb_back.sv */
// Channel sequencer: holds channel state, walks channels, drives the result register.
`default_nettype none
module acb_back #(
    parameter int CHANNELS   = acb_pkg::CHANNELS_DEF,
    parameter int MAX_FRAMES = acb_pkg::MAX_FRAMES_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              critical_mode,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire acb_pkg::cmd_t     cmd,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output acb_pkg::out_item_t     out_item
);
    import acb_pkg::*;

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FW = $clog2(MAX_FRAMES);
    localparam int TW = $clog2(MAX_FRAMES + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXEC = 4'd1;
    localparam logic [3:0] S_CH   = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_DIV2 = 4'd4;
    localparam logic [3:0] S_SHOW = 4'd5;
    localparam logic [3:0] S_LINK = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    localparam logic [1:0] P_TICK   = 2'd0;
    localparam logic [1:0] P_ALIGN  = 2'd1;
    localparam logic [1:0] P_REPORT = 2'd2;

    logic [30:0]   period_reg [CHANNELS];
    logic [TW-1:0] total_reg  [CHANNELS];
    logic [30:0]   remt_reg   [CHANNELS];
    logic [FW-1:0] cur_reg    [CHANNELS];
    logic [4:0]    flags_reg  [CHANNELS];
    logic [3:0]    link_reg   [CHANNELS];

    logic [3:0]    state_reg, state_next;
    logic [1:0]    pass_reg, pass_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          done_reg, done_next;
    logic          cond_reg, cond_next;
    cmd_t          cmd_reg, cmd_next;
    out_item_t     pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    out_item_t     out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic [CW-1:0] ch_addr, link_addr;
    logic [30:0]   p_c, r_c;
    logic [TW-1:0] tot_c;
    logic [FW-1:0] f_c, f_link;
    logic [4:0]    fl_c;
    logic [3:0]    lk_c;
    logic          idle_c, show_link, at_end, out_free, can_push;
    logic [31:0]   t;

    logic          emit;
    out_item_t     emit_item;
    logic          flush;
    logic          we_load, we_rem, we_cur, we_flags;
    logic [30:0]   rem_wdata;
    logic [FW-1:0] cur_wdata;
    logic [4:0]    flags_wdata;
    logic [TW-1:0] tot_load;

    logic          div_start, div_done;
    logic [31:0]   div_a, div_q;
    logic [30:0]   div_b, div_r;
    logic [31:0]   lim;
    logic [TW:0]   sum;

    acb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign t         = cmd_reg.item.time_value;
    assign ch_addr   = (state_reg == S_EXEC) ? CW'(cmd_reg.item.channel) : idx_reg;
    assign p_c       = period_reg[ch_addr];
    assign r_c       = remt_reg[ch_addr];
    assign tot_c     = total_reg[ch_addr];
    assign f_c       = cur_reg[ch_addr];
    assign fl_c      = flags_reg[ch_addr];
    assign lk_c      = link_reg[ch_addr];
    assign link_addr = CW'(lk_c);
    assign f_link    = cur_reg[link_addr];
    assign idle_c    = (p_c == '0) || (tot_c == '0);
    assign show_link = fl_c[FL_LINK] && critical_mode && (32'(lk_c) < CHANNELS);
    assign at_end    = idx_reg == CW'(CHANNELS - 1);
    assign out_free  = !out_valid_reg || out_ready;
    assign can_push  = !pend_valid_reg || out_free;
    assign cmd_ready = state_reg == S_IDLE;
    assign lim       = 32'(tot_c) - 32'(f_c) - 32'd1;
    assign sum       = (TW+1)'(f_c) + (TW+1)'(div_r) + (TW+1)'(1);
    assign tot_load  = (32'(cmd_reg.item.frame_total) > MAX_FRAMES) ?
                       TW'(MAX_FRAMES) : TW'(cmd_reg.item.frame_total);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    always_comb
    begin
        state_next  = state_reg;
        pass_next   = pass_reg;
        idx_next    = idx_reg;
        done_next   = done_reg;
        cond_next   = cond_reg;
        cmd_next    = cmd_reg;
        emit        = 1'b0;
        emit_item   = '{out_channel: 4'(idx_reg), frame_index: '0, one_shot_done: 1'b0,
                        last: 1'b0};
        flush       = 1'b0;
        we_load     = 1'b0;
        we_rem      = 1'b0;
        we_cur      = 1'b0;
        we_flags    = 1'b0;
        rem_wdata   = '0;
        cur_wdata   = '0;
        flags_wdata = fl_c;
        div_start   = 1'b0;
        div_a       = '0;
        div_b       = p_c;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    idx_next = '0;
                    case (cmd.op)
                        OP_TICK:
                        begin
                            pass_next  = P_TICK;
                            state_next = S_CH;
                        end
                        OP_ALIGN:
                        begin
                            pass_next  = P_ALIGN;
                            state_next = S_CH;
                        end
                        OP_RSTALL:
                        begin
                            pass_next  = P_REPORT;
                            state_next = S_CH;
                        end
                        OP_LOAD, OP_STOP, OP_RESTART:
                        begin
                            state_next = S_EXEC;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EXEC:
            begin
                case (cmd_reg.op)
                    OP_LOAD:
                    begin
                        we_load    = 1'b1;
                        state_next = S_FIN;
                    end
                    OP_STOP:
                    begin
                        if (!fl_c[FL_TGT] || can_push)
                        begin
                            we_flags             = 1'b1;
                            flags_wdata[FL_STOP] = 1'b1;
                            we_cur               = 1'b1;
                            emit                 = fl_c[FL_TGT];
                            emit_item.out_channel = cmd_reg.item.channel;
                            state_next           = S_FIN;
                        end
                    end
                    default:
                    begin
                        we_flags             = 1'b1;
                        flags_wdata[FL_STOP] = 1'b0;
                        state_next           = S_FIN;
                    end
                endcase
            end
            S_CH:
            begin
                done_next = 1'b0;
                case (pass_reg)
                    P_TICK:
                    begin
                        if (!fl_c[FL_TGT] || fl_c[FL_STOP])
                        begin
                            state_next = S_SHOW;
                        end
                        else if (idle_c)
                        begin
                            state_next = S_SHOW;
                        end
                        else if ({1'b0, r_c} >= t)
                        begin
                            we_rem     = 1'b1;
                            rem_wdata  = 31'({1'b0, r_c} - t);
                            state_next = S_SHOW;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_a      = t - 32'(r_c) - 32'd1;
                            state_next = S_DIV1;
                        end
                    end
                    P_ALIGN:
                    begin
                        we_flags             = 1'b1;
                        flags_wdata[FL_STOP] = 1'b0;
                        flags_wdata[FL_ONE]  = 1'b0;
                        if (idle_c || t == '0)
                        begin
                            we_rem    = 1'b1;
                            rem_wdata = idle_c ? '0 : p_c;
                            we_cur    = 1'b1;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            div_a      = t - 32'd1;
                            state_next = S_DIV1;
                        end
                    end
                    default:
                    begin
                        we_flags             = 1'b1;
                        flags_wdata[FL_STOP] = 1'b0;
                        flags_wdata[FL_ONE]  = 1'b0;
                        if (fl_c[FL_TGT] && !fl_c[FL_CRIT])
                        begin
                            state_next = S_SHOW;
                        end
                    end
                endcase
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    we_rem     = 1'b1;
                    rem_wdata  = p_c - div_r - 31'd1;
                    cond_next  = div_q >= lim;
                    div_start  = 1'b1;
                    div_a      = div_q;
                    div_b      = 31'(tot_c);
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    we_cur = 1'b1;
                    if (pass_reg == P_TICK)
                    begin
                        cur_wdata  = (sum >= (TW+1)'(tot_c)) ?
                                     FW'(sum - (TW+1)'(tot_c)) : FW'(sum);
                        if (cond_reg && fl_c[FL_ONE])
                        begin
                            we_flags            = 1'b1;
                            flags_wdata[FL_ONE] = 1'b0;
                            done_next           = 1'b1;
                        end
                        state_next = S_SHOW;
                    end
                    else
                    begin
                        cur_wdata  = FW'(div_r);
                        state_next = S_CH;
                    end
                end
            end
            S_SHOW:
            begin
                if (pass_reg == P_TICK && (!fl_c[FL_TGT] || fl_c[FL_STOP]))
                begin
                    state_next = S_CH;
                end
                else if (fl_c[FL_CRIT])
                begin
                    if (!done_reg || can_push)
                    begin
                        emit                    = done_reg;
                        emit_item.one_shot_done = 1'b1;
                        state_next              = S_CH;
                    end
                end
                else if (show_link)
                begin
                    state_next = S_LINK;
                end
                else if (can_push)
                begin
                    emit                    = 1'b1;
                    emit_item.frame_index   = 6'(f_c);
                    emit_item.one_shot_done = done_reg;
                    state_next              = S_CH;
                end
            end
            S_LINK:
            begin
                if (can_push)
                begin
                    emit                    = 1'b1;
                    emit_item.frame_index   = 6'(f_link);
                    emit_item.one_shot_done = done_reg;
                    state_next              = S_CH;
                end
            end
            S_FIN:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // advance to the next channel once this one is finished
        if (state_reg != S_IDLE && state_reg != S_EXEC && state_reg != S_FIN &&
            state_next == S_CH && !(state_reg == S_CH && pass_reg == P_TICK &&
            state_next == S_CH && 1'b0))
        begin
            if (state_reg == S_CH && state_next == S_CH)
            begin
                state_next = S_CH;
            end
            if (at_end)
            begin
                if (pass_reg == P_ALIGN)
                begin
                    pass_next = P_REPORT;
                    idx_next  = '0;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            else
            begin
                idx_next = idx_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        if (emit)
        begin
            pend_next       = emit_item;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_next.last  = 1'b0;
                out_valid_next = 1'b1;
            end
        end
        else if (flush)
        begin
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
        cond_reg <= cond_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pass_reg       <= P_TICK;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pass_reg       <= pass_next;
            idx_reg        <= idx_next;
            done_reg       <= done_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                period_reg[i] <= '0;
                total_reg[i]  <= '0;
                remt_reg[i]   <= '0;
                cur_reg[i]    <= '0;
                flags_reg[i]  <= '0;
                link_reg[i]   <= '0;
            end
        end
        else if (we_load)
        begin
            period_reg[ch_addr] <= cmd_reg.item.frame_period;
            total_reg[ch_addr]  <= tot_load;
            remt_reg[ch_addr]   <= cmd_reg.item.frame_period;
            cur_reg[ch_addr]    <= '0;
            flags_reg[ch_addr]  <= {cmd_reg.item.link_enable, cmd_reg.item.has_target,
                                    cmd_reg.item.critical_only, cmd_reg.item.one_shot, 1'b0};
            link_reg[ch_addr]   <= cmd_reg.item.link_channel;
        end
        else
        begin
            if (we_rem)
            begin
                remt_reg[ch_addr] <= rem_wdata;
            end
            if (we_cur)
            begin
                cur_reg[ch_addr] <= cur_wdata;
            end
            if (we_flags)
            begin
                flags_reg[ch_addr] <= flags_wdata;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/animation_channel_bank_core.sv */
// Top level of the animation channel bank: front queue, channel sequencer, mode register.
//
//  channel   signals                        direction  item
//  input     in_valid / in_ready / in_item  in         one command
//  output    out_valid / out_ready / out_item out      one channel report
//  config    cfg_wr_en / cfg_wr_data        in         critical mode bit
//
// A tick skips stopped, targetless and idle channels and runs the shared serial divider
// twice for each channel that advances. Align runs it twice per active channel when the
// time is nonzero, then a report pass. Load, stop and restart act on a single channel.
// Reset clears all channel state at once.
// A stalled output holds the sequencer; the two-item input queue accepts until full.
`default_nettype none
module animation_channel_bank_core #(
    parameter int CHANNELS   = acb_pkg::CHANNELS_DEF,
    parameter int MAX_FRAMES = acb_pkg::MAX_FRAMES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire acb_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output acb_pkg::out_item_t      out_item,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data
);
    import acb_pkg::*;

    logic crit_mode_reg, crit_mode_next;
    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    assign crit_mode_next = cfg_wr_en ? cfg_wr_data : crit_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crit_mode_reg <= 1'b0;
        end
        else
        begin
            crit_mode_reg <= crit_mode_next;
        end
    end

    acb_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    acb_back #(
        .CHANNELS   (CHANNELS),
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .critical_mode (crit_mode_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_item      (out_item)
    );
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking testbench for the animation channel bank: directed table, random items, predictor.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import acb_pkg::*;

    localparam int NCH = 16;
    localparam int MAXF = 64;
    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_item;
    logic out_valid;
    logic out_ready;
    out_item_t out_item;
    logic cfg_wr_en;
    logic cfg_wr_data;

    animation_channel_bank_core DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    // predictor state
    logic [30:0] ch_period [NCH];
    logic [6:0]  ch_total [NCH];
    logic [32:0] ch_left [NCH];
    logic [5:0]  ch_frame [NCH];
    logic [4:0]  ch_flags [NCH];
    logic [3:0]  ch_link [NCH];
    logic        crit_mode;

    out_item_t frame_reports [$];
    out_item_t pending [$];
    int errors;
    int cycles;

    typedef struct {
        in_item_t    item;
        bit          has_fixed;
        out_item_t   fixed;
    } row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [5:0] wrapped(int c);
        if (ch_total[c] == 0)
            return 6'd0;
        return 6'(ch_frame[c] % ch_total[c]);
    endfunction

    function automatic logic [5:0] displayed(int c);
        if (ch_flags[c][FL_LINK] && crit_mode)
            return wrapped(ch_link[c]);
        return wrapped(c);
    endfunction

    function automatic bit advance(int c, logic [31:0] e);
        longint unsigned p, r, tot, d, k, f;
        p = ch_period[c];
        r = ch_left[c];
        tot = ch_total[c];
        if (p == 0 || tot == 0)
            return 1'b0;
        if (r >= e)
        begin
            ch_left[c] = 33'(r - e);
            return 1'b0;
        end
        d = e - r;
        k = (d + p - 1) / p;
        ch_left[c] = 33'(k * p - d);
        f = ch_frame[c];
        if (f >= tot)
            f = tot - 1;
        ch_frame[c] = 6'((f + k % tot) % tot);
        if (f + k >= tot && ch_flags[c][FL_ONE])
        begin
            ch_flags[c][FL_ONE] = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void push_report(int c, logic [5:0] f, logic d);
        out_item_t o;
        o.out_channel = 4'(c);
        o.frame_index = f;
        o.one_shot_done = d;
        o.last = 1'b0;
        pending.push_back(o);
    endfunction

    function automatic void report_all();
        for (int c = 0; c < NCH; c++)
            if (ch_flags[c][FL_TGT] && !ch_flags[c][FL_CRIT])
                push_report(c, displayed(c), 1'b0);
    endfunction

    function automatic void predict_item(in_item_t it);
        longint unsigned t, p, rm;
        bit d;
        int ch;
        pending.delete();
        t = it.time_value;
        ch = it.channel;
        case (it.mode)
            MODE_TICK:
                for (int c = 0; c < NCH; c++)
                begin
                    if (!ch_flags[c][FL_TGT] || ch_flags[c][FL_STOP])
                        continue;
                    d = advance(c, it.time_value);
                    if (!ch_flags[c][FL_CRIT])
                        push_report(c, displayed(c), d);
                    else if (d)
                        push_report(c, 6'd0, 1'b1);
                end
            MODE_LOAD:
            begin
                ch_period[ch] = it.frame_period;
                ch_total[ch] = (it.frame_total > MAXF) ? 7'(MAXF) : it.frame_total;
                ch_left[ch] = {2'b00, it.frame_period};
                ch_frame[ch] = 6'd0;
                ch_flags[ch] = 5'd0;
                ch_flags[ch][FL_ONE] = it.one_shot;
                ch_flags[ch][FL_CRIT] = it.critical_only;
                ch_flags[ch][FL_TGT] = it.has_target;
                ch_flags[ch][FL_LINK] = it.link_enable;
                ch_link[ch] = it.link_channel;
            end
            MODE_STOP:
            begin
                ch_flags[ch][FL_STOP] = 1'b1;
                ch_frame[ch] = 6'd0;
                if (ch_flags[ch][FL_TGT])
                    push_report(ch, 6'd0, 1'b0);
            end
            MODE_RESTART:
                ch_flags[ch][FL_STOP] = 1'b0;
            MODE_ALIGN:
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    ch_flags[c][FL_STOP] = 1'b0;
                    ch_flags[c][FL_ONE] = 1'b0;
                    p = ch_period[c];
                    if (p == 0 || ch_total[c] == 0)
                    begin
                        ch_frame[c] = 6'd0;
                        ch_left[c] = 33'd0;
                    end
                    else if (t == 0)
                    begin
                        ch_frame[c] = 6'd0;
                        ch_left[c] = 33'(p);
                    end
                    else
                    begin
                        ch_frame[c] = 6'(((t - 1) / p) % ch_total[c]);
                        rm = t % p;
                        ch_left[c] = (rm != 0) ? 33'(p - rm) : 33'd0;
                    end
                end
                report_all();
            end
            MODE_RSTALL:
            begin
                for (int c = 0; c < NCH; c++)
                begin
                    ch_flags[c][FL_STOP] = 1'b0;
                    ch_flags[c][FL_ONE] = 1'b0;
                end
                report_all();
            end
            default: ;
        endcase
        if (pending.size() > 0)
            pending[pending.size() - 1].last = 1'b1;
        foreach (pending[i])
            frame_reports.push_back(pending[i]);
    endfunction

    function automatic in_item_t make_item(logic [2:0] m, logic [3:0] c, logic [31:0] t);
        in_item_t it;
        it = '0;
        it.mode = m;
        it.channel = c;
        it.time_value = t;
        return it;
    endfunction

    function automatic in_item_t make_load(logic [3:0] c, logic [30:0] p, logic [6:0] tot,
                                           logic [3:0] fl, logic [3:0] lk);
        in_item_t it;
        it = make_item(MODE_LOAD, c, $urandom());
        it.frame_period = p;
        it.frame_total = tot;
        {it.one_shot, it.critical_only, it.has_target, it.link_enable} = fl;
        it.link_channel = lk;
        return it;
    endfunction

    function automatic in_item_t random_item();
        in_item_t it;
        int r;
        logic [30:0] p;
        r = $urandom_range(0, 99);
        it = '0;
        it.channel = 4'($urandom());
        if (r < 30)
        begin
            case ($urandom_range(0, 3))
                0: p = 31'($urandom());
                1: p = 31'($urandom_range(0, 3));
                default: p = 31'($urandom_range(1, 32'h40000));
            endcase
            it = make_load(4'($urandom()), p, 7'($urandom_range(0, 127)),
                           4'($urandom()) | 4'b0010, 4'($urandom()));
            if ($urandom_range(0, 3) == 0)
                it.has_target = 1'b0;
        end
        else if (r < 70)
        begin
            it.mode = MODE_TICK;
            it.time_value = ($urandom_range(0, 4) == 0) ? $urandom()
                                                        : 32'($urandom_range(0, 32'h80000));
        end
        else if (r < 78)
            it.mode = MODE_STOP;
        else if (r < 86)
            it.mode = MODE_RESTART;
        else if (r < 92)
        begin
            it.mode = MODE_ALIGN;
            it.time_value = $urandom();
        end
        else if (r < 97)
            it.mode = MODE_RSTALL;
        else
            it.mode = 3'($urandom_range(6, 7));
        it.time_value = (it.mode == MODE_LOAD) ? $urandom() : it.time_value;
        if (it.mode != MODE_LOAD && $urandom_range(0, 1))
        begin
            it.frame_period = 31'($urandom());
            it.frame_total = 7'($urandom());
            it.link_channel = 4'($urandom());
            {it.one_shot, it.critical_only, it.has_target, it.link_enable} = 4'($urandom());
        end
        return it;
    endfunction

    // drive one item with bursts and gaps; predict at acceptance
    task automatic send_item(in_item_t it);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (frame_reports.size() > 0)
            @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task automatic write_mode(logic v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        crit_mode = v;
    endtask

    // receiver: stall on its own pattern, check at acceptance
    initial
    begin
        int phase;
        out_item_t exp_o;
        out_ready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                if (frame_reports.size() == 0)
                begin
                    $display("%0t: unexpected item, actual %p", $realtime, out_item);
                    errors++;
                end
                else
                begin
                    exp_o = frame_reports.pop_front();
                    if (out_item !== exp_o)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p",
                                 $realtime, exp_o, out_item);
                        errors++;
                    end
                end
            end
            phase++;
            if ((phase / 200) % 3 == 2)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0) && (phase % 7 != 3);
        end
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        row_t rows [$];
        row_t rw;
        out_item_t fx;
        in_item_t it;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        errors = 0;
        for (int c = 0; c < NCH; c++)
        begin
            ch_period[c] = '0; ch_total[c] = '0; ch_left[c] = '0;
            ch_frame[c] = '0; ch_flags[c] = '0; ch_link[c] = '0;
        end
        crit_mode = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset nothing has a target
        rw.item = make_item(MODE_TICK, 4'd0, 32'hFFFF_FFFF); rw.has_fixed = 0; rows.push_back(rw);
        rw.item = make_item(MODE_RSTALL, 4'd0, 32'd0); rows.push_back(rw);
        rw.item = make_load(4'd0, 31'h1_0000, 7'd4, 4'b1010, 4'd0); rows.push_back(rw);
        rw.item = make_load(4'd1, 31'h7FFF_FFFF, 7'd127, 4'b0011, 4'd0); rows.push_back(rw);
        rw.item = make_load(4'd2, 31'd1, 7'd3, 4'b1110, 4'd0); rows.push_back(rw);
        rw.item = make_load(4'd3, 31'd0, 7'd5, 4'b0010, 4'd15); rows.push_back(rw);
        rw.item = make_load(4'd15, 31'h8000, 7'd0, 4'b0011, 4'd1); rows.push_back(rw);
        rw.item = make_load(4'd4, 31'd5, 7'd64, 4'b0001, 4'd4); rows.push_back(rw);
        rw.item = make_item(MODE_TICK, 4'd0, 32'd0); rows.push_back(rw);
        rw.item = make_item(MODE_TICK, 4'd0, 32'h4_0001); rows.push_back(rw);
        rw.item = make_item(MODE_TICK, 4'd0, 32'hFFFF_FFFF); rows.push_back(rw);
        // stop of a channel with a target gives frame 0
        fx.out_channel = 4'd1; fx.frame_index = 6'd0; fx.one_shot_done = 1'b0; fx.last = 1'b1;
        rw.item = make_item(MODE_STOP, 4'd1, 32'd0); rw.has_fixed = 1; rw.fixed = fx;
        rows.push_back(rw);
        rw.has_fixed = 0;
        rw.item = make_item(MODE_STOP, 4'd4, 32'd0); rows.push_back(rw);
        rw.item = make_item(MODE_TICK, 4'd0, 32'h1234); rows.push_back(rw);
        rw.item = make_item(MODE_RESTART, 4'd1, 32'd0); rows.push_back(rw);
        rw.item = make_item(MODE_ALIGN, 4'd0, 32'd0); rows.push_back(rw);
        rw.item = make_item(MODE_ALIGN, 4'd0, 32'h3_0000); rows.push_back(rw);
        rw.item = make_item(MODE_ALIGN, 4'd0, 32'hFFFF_FFFF); rows.push_back(rw);
        rw.item = make_item(3'd6, 4'd0, 32'd0); rows.push_back(rw);
        rw.item = make_item(3'd7, 4'd0, 32'hFFFF_FFFF); rows.push_back(rw);
        rw.item = make_item(MODE_RSTALL, 4'd0, 32'd0); rows.push_back(rw);

        foreach (rows[i])
        begin
            if (i == 16)
            begin
                wait_drained();
                write_mode(1'b1);
            end
            send_item(rows[i].item);
            if (rows[i].has_fixed)
            begin
                if (pending.size() != 1)
                begin
                    $display("%0t: mismatch, expected %p, actual %0d items", $realtime,
                             rows[i].fixed, pending.size());
                    errors++;
                end
                else if (pending[0] !== rows[i].fixed)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $realtime,
                             rows[i].fixed, pending[0]);
                    errors++;
                end
            end
        end

        for (int n = 0; n < 80; n++)
        begin
            if (n % 30 == 29)
            begin
                wait_drained();
                write_mode(1'($urandom()));
            end
            it = random_item();
            send_item(it);
        end
        wait_drained();
        write_mode(1'b0);
        send_item(make_item(MODE_TICK, 4'd0, 32'h2_0000));
        wait_drained();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

/* animation_channel_bank_core.f */
rtl/acb_pkg.sv
rtl/acb_front.sv
rtl/acb_div.sv
rtl/acb_back.sv
rtl/animation_channel_bank_core.sv
tb/sv/testbench.sv
